@@ sv/pstod_pkg.sv @@
`timescale 1ns / 1ps
// pstod_pkg: item codes, field widths and event flag type for the time-of-day keeper
// no dependencies

package pstod_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_RESYNC = 2'd1,
        MODE_LOAD   = 2'd2
    } mode_t;

    localparam int WALL_W   = 32;
    localparam int SEC_W    = 17;
    localparam int MS_W     = 10;
    localparam int DAYMS_W  = 27;

    typedef struct packed {
        logic second_event;
        logic sync_request;
        logic sync_lost;
        logic sync_gained;
        logic pulse_missing;
    } tod_flags_t;

endpackage

@@ sv/pps_synced_time_of_day.sv @@
`timescale 1ns / 1ps
// pps_synced_time_of_day: time-of-day keeper locked to a once-per-second pulse
// depends on pstod_pkg

// One item per clock cycle sustained while the output is not stalled.
// Items pass an input register, two stages that reduce wall_seconds modulo
// SECONDS_PER_DAY by a reciprocal multiply and a multiply-back, a stage that
// corrects the remainder and updates the clock state, and
// an output register that forms day_millis with one multiply and add. The
// state is read and written only in the update stage, so back-to-back items
// see each other's effects in order. Each stage holds its item while the next
// is full and stalled, so bubbles are squeezed out behind a stalled result.

module pps_synced_time_of_day
    import pstod_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int SECONDS_PER_DAY  = 86400
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic                 pulse_level,
    input  logic [WALL_W-1:0]    wall_seconds,
    input  logic                 first_half,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SEC_W-1:0]     day_seconds,
    output logic [MS_W-1:0]      milliseconds,
    output logic [DAYMS_W-1:0]   day_millis,
    output logic                 synced,
    output logic                 second_event,
    output logic                 sync_request,
    output logic                 sync_lost,
    output logic                 sync_gained,
    output logic                 pulse_missing
);

    localparam int CNT_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int REM_W = SEC_W + 1;
    localparam int SHIFT = 31 + $clog2(SECONDS_PER_DAY);
    localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(SECONDS_PER_DAY);
    localparam logic [WALL_W-1:0] RECIP = RECIP_WIDE[WALL_W-1:0];
    localparam logic [SEC_W-1:0]  DAY_LEN = SEC_W'(SECONDS_PER_DAY);
    localparam logic [REM_W-1:0]  DAY_LEN_R = REM_W'(SECONDS_PER_DAY);
    localparam logic [CNT_W-1:0]  TICKS = CNT_W'(TICKS_PER_SECOND);

    // pipeline occupancy
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: input register
    logic [1:0]        s1_mode_reg;
    logic              s1_pulse_reg;
    logic [WALL_W-1:0] s1_wall_reg;
    logic              s1_half_reg;

    // stage 2: quotient estimate
    logic [1:0]        s2_mode_reg;
    logic              s2_pulse_reg;
    logic [WALL_W-1:0] s2_wall_reg;
    logic              s2_half_reg;
    logic [WALL_W-1:0] s2_quot_reg;
    logic [WALL_W-1:0] s2_quot_next;
    logic [63:0]       recip_prod;

    // stage 3: raw remainder, below twice the day length
    logic [1:0]        s3_mode_reg;
    logic              s3_pulse_reg;
    logic              s3_half_reg;
    logic [REM_W-1:0]  s3_rem_reg;
    logic [REM_W-1:0]  s3_rem_next;
    logic [WALL_W-1:0] back_prod;
    logic [WALL_W-1:0] rem_full;

    // clock state
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [CNT_W-1:0]  ms_reg, ms_next;
    logic              sync_reg, sync_next;
    logic              last_pulse_reg, last_pulse_next;

    // stage 4: result before day_millis
    logic [SEC_W-1:0]  s4_sec_reg;
    logic [CNT_W-1:0]  s4_ms_reg;
    logic              s4_sync_reg;
    tod_flags_t        s4_flags_reg;
    tod_flags_t        flags_next;

    // output register
    logic [SEC_W-1:0]   out_sec_reg;
    logic [MS_W-1:0]    out_ms_reg;
    logic [DAYMS_W-1:0] out_dayms_reg;
    logic [DAYMS_W-1:0] out_dayms_next;
    logic               out_sync_reg;
    tod_flags_t         out_flags_reg;

    // update stage working values
    logic [REM_W-1:0] rem_fix;
    logic [SEC_W-1:0] load_sec;
    logic [SEC_W-1:0] sec_inc;
    logic [CNT_W-1:0] ms_inc;
    logic             pulse_edge;

    always_comb
    begin
        rdy5 = !out_valid_reg || !out_stall;
        rdy4 = !s4_valid_reg || rdy5;
        rdy3 = !s3_valid_reg || rdy4;
        rdy2 = !s2_valid_reg || rdy3;
        rdy1 = !s1_valid_reg || rdy2;
    end

    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // quotient estimate is the true quotient or one short
    always_comb
    begin
        recip_prod   = 64'(s1_wall_reg) * 64'(RECIP);
        s2_quot_next = WALL_W'(recip_prod >> SHIFT);
    end

    always_comb
    begin
        back_prod   = WALL_W'(s2_quot_reg * WALL_W'(SECONDS_PER_DAY));
        rem_full    = s2_wall_reg - back_prod;
        s3_rem_next = rem_full[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            s1_mode_reg  <= mode;
            s1_pulse_reg <= pulse_level;
            s1_wall_reg  <= wall_seconds;
            s1_half_reg  <= first_half;
        end
        if (s1_valid_reg && rdy2)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_pulse_reg <= s1_pulse_reg;
            s2_wall_reg  <= s1_wall_reg;
            s2_half_reg  <= s1_half_reg;
            s2_quot_reg  <= s2_quot_next;
        end
        if (s2_valid_reg && rdy3)
        begin
            s3_mode_reg  <= s2_mode_reg;
            s3_pulse_reg <= s2_pulse_reg;
            s3_half_reg  <= s2_half_reg;
            s3_rem_reg   <= s3_rem_next;
        end
        if (s3_valid_reg && rdy4)
        begin
            s4_sec_reg   <= sec_next;
            s4_ms_reg    <= ms_next;
            s4_sync_reg  <= sync_next;
            s4_flags_reg <= flags_next;
        end
        if (s4_valid_reg && rdy5)
        begin
            out_sec_reg   <= s4_sec_reg;
            out_ms_reg    <= MS_W'(s4_ms_reg);
            out_dayms_reg <= out_dayms_next;
            out_sync_reg  <= s4_sync_reg;
            out_flags_reg <= s4_flags_reg;
        end
    end

    // state update
    always_comb
    begin
        sec_next        = sec_reg;
        ms_next         = ms_reg;
        sync_next       = sync_reg;
        last_pulse_next = last_pulse_reg;
        flags_next      = '0;

        rem_fix  = (s3_rem_reg >= DAY_LEN_R) ? s3_rem_reg - DAY_LEN_R : s3_rem_reg;
        load_sec = rem_fix[SEC_W-1:0];
        if (s3_half_reg)
        begin
            load_sec = (load_sec == '0) ? DAY_LEN - 1'b1 : load_sec - 1'b1;
        end

        sec_inc    = sec_reg + 1'b1;
        ms_inc     = ms_reg + 1'b1;
        pulse_edge = !sync_reg && s3_pulse_reg && !last_pulse_reg;

        case (s3_mode_reg)
            MODE_TICK:
            begin
                ms_next = ms_inc;
                if (pulse_edge)
                begin
                    ms_next                 = '0;
                    flags_next.sync_request = 1'b1;
                end
                if (pulse_edge || ms_inc >= TICKS)
                begin
                    flags_next.second_event = 1'b1;
                    if (sync_reg)
                    begin
                        // a synced boundary must land on a fresh rising edge
                        if (!s3_pulse_reg || last_pulse_reg)
                        begin
                            sync_next            = 1'b0;
                            flags_next.sync_lost = 1'b1;
                        end
                    end
                    else if (!pulse_edge)
                    begin
                        flags_next.pulse_missing = 1'b1;
                    end
                    sec_next = (sec_inc >= DAY_LEN) ? '0 : sec_inc;
                    ms_next  = '0;
                end
                last_pulse_next = s3_pulse_reg;
            end
            MODE_RESYNC:
            begin
                sync_next            = 1'b0;
                flags_next.sync_lost = 1'b1;
            end
            MODE_LOAD:
            begin
                sec_next               = load_sec;
                sync_next              = 1'b1;
                flags_next.sync_gained = 1'b1;
            end
            default:
            begin
                sync_next = sync_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg        <= '0;
            ms_reg         <= '0;
            sync_reg       <= 1'b0;
            last_pulse_reg <= 1'b0;
        end
        else if (s3_valid_reg && rdy4)
        begin
            sec_reg        <= sec_next;
            ms_reg         <= ms_next;
            sync_reg       <= sync_next;
            last_pulse_reg <= last_pulse_next;
        end
    end

    always_comb
    begin
        out_dayms_next = DAYMS_W'(34'(s4_sec_reg) * 34'(TICKS_PER_SECOND) + 34'(s4_ms_reg));
    end

    assign out_valid     = out_valid_reg;
    assign day_seconds   = out_sec_reg;
    assign milliseconds  = out_ms_reg;
    assign day_millis    = out_dayms_reg;
    assign synced        = out_sync_reg;
    assign second_event  = out_flags_reg.second_event;
    assign sync_request  = out_flags_reg.sync_request;
    assign sync_lost     = out_flags_reg.sync_lost;
    assign sync_gained   = out_flags_reg.sync_gained;
    assign pulse_missing = out_flags_reg.pulse_missing;

    // clock state stays in range
    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg < TICKS)
        else $error("millisecond count out of range");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg < DAY_LEN)
        else $error("seconds of day out of range");

    a_gain_synced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sync_gained |-> synced)
        else $error("sync gained without synced flag");

    a_lost_unsynced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sync_lost |-> !synced)
        else $error("sync lost while still synced");

    a_request_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sync_request |-> second_event && out_ms_reg == '0 && !pulse_missing)
        else $error("sync request off a second boundary");

endmodule

@@ tb/pps_synced_time_of_day_tb.sv @@
`timescale 1ns / 1ps
// pps_synced_time_of_day_tb: self-checking bench for the pulse-locked time-of-day keeper
// depends on pstod_pkg and pps_synced_time_of_day; predicts every result and checks it in order

module pps_synced_time_of_day_tb
    import pstod_pkg::*;
();

    localparam int TICKS_PER_SEC = 1000;
    localparam int SEC_PER_DAY   = 86400;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int NOISE_ITEMS   = 20;
    localparam int TRAIN_ITEMS   = 123;
    localparam int MAX_REPORTED  = 10;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [SEC_W-1:0]   day_sec;
        logic [MS_W-1:0]    ms;
        logic [DAYMS_W-1:0] day_ms;
        logic               synced;
        tod_flags_t         flags;
    } tod_result_t;

    // own copy of the clock state, advanced once per accepted item
    class time_of_day_tracker;
        int          day_sec;
        int          ms_count;
        bit          locked;
        bit          prev_pulse;
        tod_result_t last;
        tod_result_t expected_times[$];
        int          n_errors;
        int          n_checked;
        int          n_second;
        int          n_request;
        int          n_lost;
        int          n_gained;
        int          n_missing;
        int          n_wraps;

        function new();
            day_sec    = 0;
            ms_count   = 0;
            locked     = 1'b0;
            prev_pulse = 1'b0;
            last       = '0;
            n_errors   = 0;
            n_checked  = 0;
            n_second   = 0;
            n_request  = 0;
            n_lost     = 0;
            n_gained   = 0;
            n_missing  = 0;
            n_wraps    = 0;
        endfunction

        function void note_item(logic [1:0] m, logic pulse, logic [31:0] wall, logic half);
            int          ms;
            bit          rose;
            int          s;
            tod_result_t r;
            r.flags = '0;
            case (m)
                MODE_TICK:
                begin
                    ms   = ms_count + 1;
                    rose = 1'b0;
                    if (!locked && pulse && !prev_pulse)
                    begin
                        ms   = 0;
                        rose = 1'b1;
                        r.flags.sync_request = 1'b1;
                    end
                    if (ms == 0 || ms >= TICKS_PER_SEC)
                    begin
                        r.flags.second_event = 1'b1;
                        if (locked)
                        begin
                            // synced second must coincide with a fresh edge
                            if (!pulse || prev_pulse)
                            begin
                                locked = 1'b0;
                                r.flags.sync_lost = 1'b1;
                            end
                        end
                        else if (!rose)
                            r.flags.pulse_missing = 1'b1;
                        if (day_sec + 1 >= SEC_PER_DAY)
                        begin
                            day_sec = 0;
                            n_wraps++;
                        end
                        else
                            day_sec = day_sec + 1;
                        ms = 0;
                    end
                    ms_count   = ms;
                    prev_pulse = pulse;
                end
                MODE_RESYNC:
                begin
                    locked = 1'b0;
                    r.flags.sync_lost = 1'b1;
                end
                MODE_LOAD:
                begin
                    s = int'(wall % 32'(SEC_PER_DAY));
                    if (half)
                        s = (s == 0) ? SEC_PER_DAY - 1 : s - 1;
                    day_sec = s;
                    locked  = 1'b1;
                    r.flags.sync_gained = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.day_sec = SEC_W'(day_sec);
            r.ms      = MS_W'(ms_count);
            r.day_ms  = DAYMS_W'(day_sec * TICKS_PER_SEC + ms_count);
            r.synced  = locked;
            n_second  += r.flags.second_event;
            n_request += r.flags.sync_request;
            n_lost    += r.flags.sync_lost;
            n_gained  += r.flags.sync_gained;
            n_missing += r.flags.pulse_missing;
            last = r;
            expected_times.push_back(r);
        endfunction

        function void check_result(tod_result_t got);
            tod_result_t want;
            n_checked++;
            if (expected_times.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTED)
                    $display("%0t: result with nothing expected: sec %0d ms %0d", $realtime,
                             got.day_sec, got.ms);
                return;
            end
            want = expected_times.pop_front();
            if (want.day_sec !== got.day_sec || want.ms !== got.ms
                || want.day_ms !== got.day_ms || want.synced !== got.synced
                || want.flags !== got.flags)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTED)
                begin
                    $display("%0t: mismatch on result %0d", $realtime, n_checked);
                    $display("  expected sec %0d ms %0d day_ms %0d synced %b flags %b",
                             want.day_sec, want.ms, want.day_ms, want.synced, want.flags);
                    $display("  actual   sec %0d ms %0d day_ms %0d synced %b flags %b",
                             got.day_sec, got.ms, got.day_ms, got.synced, got.flags);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           mode;
    logic                 pulse_level;
    logic [WALL_W-1:0]    wall_seconds;
    logic                 first_half;
    logic                 out_valid;
    logic                 out_stall;
    logic [SEC_W-1:0]     day_seconds;
    logic [MS_W-1:0]      milliseconds;
    logic [DAYMS_W-1:0]   day_millis;
    logic                 synced;
    logic                 second_event;
    logic                 sync_request;
    logic                 sync_lost;
    logic                 sync_gained;
    logic                 pulse_missing;

    time_of_day_tracker   clock_model;
    tod_result_t          seen_time;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   n_sent = 0;
    int                   hold_at = -1;
    int                   hold_left = 0;
    bit                   hold_done = 1'b0;
    int                   cycle_count = 0;
    int                   pulse_hold = 0;
    bit                   eager_edges = 1'b1;

    pps_synced_time_of_day #(
        .TICKS_PER_SECOND (TICKS_PER_SEC),
        .SECONDS_PER_DAY  (SEC_PER_DAY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pulse_level   (pulse_level),
        .wall_seconds  (wall_seconds),
        .first_half    (first_half),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .day_seconds   (day_seconds),
        .milliseconds  (milliseconds),
        .day_millis    (day_millis),
        .synced        (synced),
        .second_event  (second_event),
        .sync_request  (sync_request),
        .sync_lost     (sync_lost),
        .sync_gained   (sync_gained),
        .pulse_missing (pulse_missing)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_time = {day_seconds, milliseconds, day_millis, synced, second_event,
                         sync_request, sync_lost, sync_gained, pulse_missing};
            clock_model.check_result(seen_time);
        end
    end

    // receiver: random stalls, plus one long hold-off so the pipe backs up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && hold_at >= 0 && n_sent >= hold_at)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic logic [31:0] pick_wall();
        logic [31:0] base;
        base = 32'($urandom_range(0, 49709)) * 32'(SEC_PER_DAY);
        case ($urandom_range(0, 5))
            0:       return base;
            1:       return base + 32'(SEC_PER_DAY - 1);
            2:       return base + 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // called just after a falling edge, returns just after a falling edge once the item is accepted
    task automatic send_item(input logic [1:0] m, input logic p, input logic [31:0] w,
                             input logic h);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        pulse_level  <= p;
        wall_seconds <= w;
        first_half   <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        clock_model.note_item(m, p, w, h);
        n_sent++;
        @(negedge clk);
    endtask

    // one item of a plausible pulse train: edges on the second, loads after requests
    task automatic send_train_item();
        logic [1:0]  m;
        logic        p;
        logic [31:0] w;
        logic        h;
        m = MODE_TICK;
        p = 1'b0;
        w = $urandom;
        h = 1'($urandom_range(0, 1));
        if (clock_model.last.flags.sync_request && $urandom_range(0, 7) != 0)
        begin
            m = MODE_LOAD;
            w = pick_wall();
        end
        else if ($urandom_range(0, 599) == 0)
            m = MODE_RESYNC;
        else if ($urandom_range(0, 49) == 0)
            m = MODE_UNUSED;
        else if ($urandom_range(0, 399) == 0)
        begin
            m = MODE_LOAD;
            w = pick_wall();
        end
        else if (pulse_hold > 0)
        begin
            p = 1'b1;
            pulse_hold--;
        end
        else if (clock_model.ms_count == TICKS_PER_SEC - 1)
        begin
            // now and then the edge goes missing on the second
            if ($urandom_range(0, 4) != 0)
            begin
                p = 1'b1;
                pulse_hold = $urandom_range(0, 250);
            end
        end
        else if (!clock_model.locked && eager_edges && $urandom_range(0, 39) == 0)
        begin
            p = 1'b1;
            pulse_hold = $urandom_range(0, 250);
        end
        if (m == MODE_TICK && $urandom_range(0, 299) == 0)
            p = ~p;
        send_item(m, p, w, h);
        if (clock_model.last.flags.second_event)
            eager_edges = 1'($urandom_range(0, 1));
    endtask

    initial
    begin
        clock_model  = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_TICK;
        pulse_level  = 1'b0;
        wall_seconds = '0;
        first_half   = 1'b0;
        out_stall    = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 73;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(MODE_TICK, 1'b0, '0, 1'b0);
        // unsynced rising edge restarts the count and asks for a load
        send_item(MODE_TICK, 1'b1, '0, 1'b0);
        send_item(MODE_TICK, 1'b1, '0, 1'b0);
        send_item(MODE_UNUSED, 1'b1, '1, 1'b1);
        // decrement from zero wraps to the last second of the day
        send_item(MODE_LOAD, 1'b0, '0, 1'b1);
        send_item(MODE_LOAD, 1'b0, '1, 1'b0);
        send_item(MODE_LOAD, 1'b1, '1, 1'b1);
        send_item(MODE_LOAD, 1'b0, 32'(SEC_PER_DAY - 1), 1'b0);
        send_item(MODE_TICK, 1'b0, '1, 1'b1);
        send_item(MODE_RESYNC, 1'b1, '0, 1'b1);
        send_item(MODE_RESYNC, 1'b0, '1, 1'b0);
        // edge at the last second of the day rolls over midnight
        send_item(MODE_TICK, 1'b1, '0, 1'b0);
        send_item(MODE_LOAD, 1'b0, 32'(SEC_PER_DAY), 1'b0);
        send_item(MODE_LOAD, 1'b0, 32'd1, 1'b1);
        send_item(MODE_TICK, 1'b0, '0, 1'b0);
        send_item(MODE_TICK, 1'b1, '0, 1'b0);
        send_item(MODE_TICK, 1'b1, '0, 1'b0);
        send_item(MODE_TICK, 1'b0, '0, 1'b0);
        send_item(MODE_LOAD, 1'b1, 32'(SEC_PER_DAY / 2), 1'b0);
        send_item(MODE_UNUSED, 1'b0, '0, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < NOISE_ITEMS; i++)
                send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                          1'($urandom_range(0, 1)));
            if (phase == 2)
                hold_at = n_sent + 40;
            for (int i = 0; i < TRAIN_ITEMS; i++)
                send_train_item();
        end
        in_valid <= 1'b0;

        while (clock_model.expected_times.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items in, %0d results checked; %0d seconds, %0d midnight wraps",
                 n_sent, clock_model.n_checked, clock_model.n_second, clock_model.n_wraps);
        $display("sync requests %0d, gained %0d, lost %0d, missing pulses %0d, errors %0d",
                 clock_model.n_request, clock_model.n_gained, clock_model.n_lost,
                 clock_model.n_missing, clock_model.n_errors);
        if (clock_model.n_errors == 0 && clock_model.expected_times.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
